/* rtl/core/best_fit_heap_allocator_top_macros.svh */
// assertion macros for the best-fit heap allocator checker
// no dependencies; included by the checker file only
`ifndef BEST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH
`define BEST_FIT_HEAP_ALLOCATOR_TOP_MACROS_SVH

// clocked assertion with async active-low reset disable
`define BFHA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// same, with a fixed message
`define BFHA_ASSERT_PLAIN(lbl, clk, rstn, prop) \
    `BFHA_ASSERT(lbl, clk, rstn, prop, "bfha check failed")

`endif

/* rtl/core/bfha_pkg.sv */
// shared types, constants and helpers for the best-fit heap allocator
// used by bfha_cell, bfha_ctrl, the top level and the checker
package bfha_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int PAGE_BITS     = 12;
    localparam int DATA_W        = 32;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam logic [DATA_W-1:0] PAGE_SIZE = DATA_W'(1) << PAGE_BITS;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOFIT    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_ZERO     = 3'd4;

    localparam logic [1:0] FN_ALLOC   = 2'd0;
    localparam logic [1:0] FN_ALIGNED = 2'd1;
    localparam logic [1:0] FN_FREE    = 2'd2;

    localparam logic REG_REGION_START = 1'b0;
    localparam logic REG_REGION_END   = 1'b1;

    typedef enum logic [1:0] {
        MODE_BEST,
        MODE_START,
        MODE_END
    } mode_t;

    // search request, held steady while a scan runs down the chain
    typedef struct packed {
        mode_t             mode;
        logic              aligned;
        logic [DATA_W-1:0] size;
        logic [DATA_W-1:0] addr;
        logic              skip_en;
        logic [IDX_W-1:0]  skip;
    } query_t;

    // scan packet handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] len;
        logic              hole;
        logic [CNT_W-1:0]  free_cnt;
        logic [IDX_W-1:0]  free1;
        logic [IDX_W-1:0]  free2;
    } pkt_t;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] len;
        logic              hole;
        logic              valid;
    } wr_t;

    typedef struct packed {
        logic              en;
        logic [DATA_W-1:0] base;
        logic [DATA_W-1:0] len;
    } rebuild_t;

    // bytes from base up to the next page boundary
    function automatic logic [DATA_W-1:0] lead_gap(input logic [DATA_W-1:0] b);
        logic [DATA_W-1:0] low;
        begin
            low = DATA_W'(b[PAGE_BITS-1:0]);
            return (low != '0) ? (PAGE_SIZE - low) : '0;
        end
    endfunction

endpackage

/* rtl/core/bfha_cell.sv */
// one table entry of the allocator plus its stage of the scan chain
// depends on bfha_pkg
module bfha_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [bfha_pkg::IDX_W-1:0]     cell_idx,
    input  bfha_pkg::query_t               query,
    input  bfha_pkg::wr_t                  wr,
    input  bfha_pkg::rebuild_t             rebuild,
    input  bfha_pkg::pkt_t                 pkt_in,
    output bfha_pkg::pkt_t                 pkt_out
);

    logic [bfha_pkg::DATA_W-1:0] base_reg;
    logic [bfha_pkg::DATA_W-1:0] len_reg;
    logic                        hole_reg;
    logic                        valid_reg;
    bfha_pkg::pkt_t              pkt_reg;
    bfha_pkg::pkt_t              pkt_next;

    logic [bfha_pkg::DATA_W-1:0] off;
    logic [bfha_pkg::DATA_W-1:0] end_addr;
    logic                        skipped;
    logic                        fit;
    logic                        better;
    logic                        take;

    always_comb
    begin
        off      = query.aligned ? bfha_pkg::lead_gap(base_reg) : '0;
        end_addr = base_reg + len_reg;
        skipped  = query.skip_en && (query.skip == cell_idx);
        fit      = (len_reg >= off) && ((len_reg - off) >= query.size);
        better   = !pkt_in.found || (len_reg < pkt_in.len) ||
                   ((len_reg == pkt_in.len) && (base_reg < pkt_in.base));
        case (query.mode)
            bfha_pkg::MODE_BEST:
                take = valid_reg && hole_reg && fit && better;
            bfha_pkg::MODE_START:
                take = valid_reg && !skipped && !pkt_in.found && (base_reg == query.addr);
            bfha_pkg::MODE_END:
                take = valid_reg && !skipped && !pkt_in.found && (end_addr == query.addr);
            default:
                take = 1'b0;
        endcase

        pkt_next = pkt_in;
        if (!valid_reg)
        begin
            pkt_next.free_cnt = pkt_in.free_cnt + bfha_pkg::CNT_W'(1);
            if (pkt_in.free_cnt == '0)
                pkt_next.free1 = cell_idx;
            if (pkt_in.free_cnt == bfha_pkg::CNT_W'(1))
                pkt_next.free2 = cell_idx;
        end
        if (take)
        begin
            pkt_next.found = 1'b1;
            pkt_next.idx   = cell_idx;
            pkt_next.base  = base_reg;
            pkt_next.len   = len_reg;
            pkt_next.hole  = hole_reg;
        end
        pkt_next.valid = pkt_in.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg  <= '0;
            len_reg   <= '0;
            hole_reg  <= (cell_idx == '0);
            valid_reg <= (cell_idx == '0);
            pkt_reg   <= '0;
        end
        else
        begin
            pkt_reg <= pkt_next;
            if (rebuild.en)
            begin
                base_reg  <= rebuild.base;
                len_reg   <= rebuild.len;
                hole_reg  <= (cell_idx == '0);
                valid_reg <= (cell_idx == '0);
            end
            else if (wr.en && (wr.idx == cell_idx))
            begin
                base_reg  <= wr.base;
                len_reg   <= wr.len;
                hole_reg  <= wr.hole;
                valid_reg <= wr.valid;
            end
        end
    end

    assign pkt_out = pkt_reg;

endmodule

/* rtl/core/bfha_ctrl.sv */
// request sequencer: launches scans, plans entry writes, holds config and result
// depends on bfha_pkg
module bfha_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   func,
    input  logic [bfha_pkg::DATA_W-1:0]  req_size,
    input  logic [bfha_pkg::DATA_W-1:0]  free_addr,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bfha_pkg::DATA_W-1:0]  block_addr,
    output logic [2:0]                   status,
    output logic [bfha_pkg::DATA_W-1:0]  used_bytes,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [bfha_pkg::DATA_W-1:0]  cfg_data,
    output bfha_pkg::query_t             query,
    output bfha_pkg::wr_t                wr,
    output bfha_pkg::rebuild_t           rebuild,
    output bfha_pkg::pkt_t               chain_in,
    input  bfha_pkg::pkt_t               chain_out
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN,
        S_AEVAL,
        S_APLAN,
        S_ACOMMIT,
        S_FREE_A,
        S_FREE_B,
        S_FREE_C,
        S_WRITE,
        S_LAUNCH_C,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_ALLOC,
        PH_A,
        PH_B,
        PH_C
    } phase_t;

    state_t                      state_reg;
    phase_t                      phase_reg;
    logic                        launch_reg;
    bfha_pkg::query_t            query_reg;
    bfha_pkg::pkt_t              res_reg;
    bfha_pkg::wr_t               wcmd_reg [3];
    logic [1:0]                  wptr_reg;
    logic                        then_c_reg;

    logic [bfha_pkg::DATA_W-1:0] region_start_reg;
    logic [bfha_pkg::DATA_W-1:0] region_end_reg;
    logic [bfha_pkg::DATA_W-1:0] bytes_used_reg;

    logic [bfha_pkg::DATA_W-1:0] off_reg;
    logic [bfha_pkg::DATA_W-1:0] rest_reg;
    logic [bfha_pkg::DATA_W-1:0] start_reg;
    logic [bfha_pkg::DATA_W-1:0] i_base_reg;
    logic [bfha_pkg::DATA_W-1:0] i_len_reg;
    logic [bfha_pkg::IDX_W-1:0]  i_idx_reg;
    logic [bfha_pkg::DATA_W-1:0] cur_base_reg;
    logic [bfha_pkg::DATA_W-1:0] cur_len_reg;
    logic [bfha_pkg::IDX_W-1:0]  cur_idx_reg;
    logic [bfha_pkg::DATA_W-1:0] res_addr_reg;
    logic [2:0]                  res_status_reg;

    logic                        out_valid_reg;
    logic [bfha_pkg::DATA_W-1:0] block_addr_reg;
    logic [2:0]                  status_reg;
    logic [bfha_pkg::DATA_W-1:0] used_bytes_reg;

    logic [bfha_pkg::DATA_W-1:0] new_start;
    logic [bfha_pkg::DATA_W-1:0] new_end;
    logic [bfha_pkg::DATA_W-1:0] a_off;
    logic [1:0]                  need;
    logic                        small_req;
    logic [bfha_pkg::DATA_W-1:0] start_plus_n;
    logic [bfha_pkg::DATA_W-1:0] rest_minus_n;
    logic [bfha_pkg::DATA_W-1:0] used_sat;
    logic [bfha_pkg::DATA_W-1:0] b_sum;
    logic [bfha_pkg::DATA_W-1:0] c_sum;
    logic [bfha_pkg::DATA_W-1:0] c_addr;
    logic                        in_acc;

    always_comb
    begin
        new_start = (cfg_index == bfha_pkg::REG_REGION_START) ? cfg_data : region_start_reg;
        new_end   = (cfg_index == bfha_pkg::REG_REGION_END) ? cfg_data : region_end_reg;
        rebuild.en   = cfg_we;
        rebuild.base = new_start;
        rebuild.len  = (new_end >= new_start) ? (new_end - new_start) : '0;

        a_off        = query_reg.aligned ? bfha_pkg::lead_gap(res_reg.base) : '0;
        small_req    = query_reg.size < rest_reg;
        need         = {1'b0, off_reg != '0} + {1'b0, small_req};
        start_plus_n = start_reg + query_reg.size;
        rest_minus_n = rest_reg - query_reg.size;
        used_sat     = (bytes_used_reg > ~query_reg.size) ? '1
                                                          : bytes_used_reg + query_reg.size;
        b_sum        = res_reg.len + i_len_reg;
        c_sum        = cur_len_reg + res_reg.len;
        c_addr       = cur_base_reg + cur_len_reg;

        wr    = wcmd_reg[wptr_reg];
        wr.en = wcmd_reg[wptr_reg].en && (state_reg == S_WRITE);

        chain_in       = '0;
        chain_in.valid = launch_reg;

        in_acc = in_valid && !in_stall;
    end

    assign in_stall   = (state_reg != S_IDLE);
    assign query      = query_reg;
    assign out_valid  = out_valid_reg;
    assign block_addr = block_addr_reg;
    assign status     = status_reg;
    assign used_bytes = used_bytes_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            phase_reg        <= PH_ALLOC;
            launch_reg       <= 1'b0;
            query_reg        <= '0;
            res_reg          <= '0;
            for (int k = 0; k < 3; k++)
                wcmd_reg[k] <= '0;
            wptr_reg         <= '0;
            then_c_reg       <= 1'b0;
            region_start_reg <= '0;
            region_end_reg   <= '0;
            bytes_used_reg   <= '0;
            off_reg          <= '0;
            rest_reg         <= '0;
            start_reg        <= '0;
            i_base_reg       <= '0;
            i_len_reg        <= '0;
            i_idx_reg        <= '0;
            cur_base_reg     <= '0;
            cur_len_reg      <= '0;
            cur_idx_reg      <= '0;
            res_addr_reg     <= '0;
            res_status_reg   <= bfha_pkg::ST_OK;
            out_valid_reg    <= 1'b0;
            block_addr_reg   <= '0;
            status_reg       <= bfha_pkg::ST_OK;
            used_bytes_reg   <= '0;
        end
        else
        begin
            // S_DONE reloads the result register itself
            if (out_valid_reg && !out_stall && (state_reg != S_DONE))
                out_valid_reg <= 1'b0;

            if (cfg_we)
            begin
                if (cfg_index == bfha_pkg::REG_REGION_START)
                    region_start_reg <= cfg_data;
                else
                    region_end_reg <= cfg_data;
                bytes_used_reg <= '0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (in_acc)
                    begin
                        res_addr_reg        <= '0;
                        res_status_reg      <= bfha_pkg::ST_OK;
                        query_reg.size      <= req_size;
                        query_reg.aligned   <= (func == bfha_pkg::FN_ALIGNED);
                        query_reg.addr      <= free_addr;
                        query_reg.skip_en   <= 1'b0;
                        query_reg.skip      <= '0;
                        if (func == bfha_pkg::FN_ALLOC || func == bfha_pkg::FN_ALIGNED)
                        begin
                            if (req_size == '0)
                            begin
                                res_status_reg <= bfha_pkg::ST_ZERO;
                                state_reg      <= S_DONE;
                            end
                            else
                            begin
                                query_reg.mode <= bfha_pkg::MODE_BEST;
                                phase_reg      <= PH_ALLOC;
                                launch_reg     <= 1'b1;
                                state_reg      <= S_SCAN;
                            end
                        end
                        else if (func == bfha_pkg::FN_FREE)
                        begin
                            query_reg.mode <= bfha_pkg::MODE_START;
                            phase_reg      <= PH_A;
                            launch_reg     <= 1'b1;
                            state_reg      <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end

                S_SCAN:
                begin
                    // launch pulse lasts the first scan cycle only
                    launch_reg <= 1'b0;
                    if (chain_out.valid)
                    begin
                        res_reg <= chain_out;
                        case (phase_reg)
                            PH_ALLOC: state_reg <= S_AEVAL;
                            PH_A:     state_reg <= S_FREE_A;
                            PH_B:     state_reg <= S_FREE_B;
                            PH_C:     state_reg <= S_FREE_C;
                            default:  state_reg <= S_IDLE;
                        endcase
                    end
                end

                S_AEVAL:
                begin
                    if (!res_reg.found)
                    begin
                        res_status_reg <= bfha_pkg::ST_NOFIT;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        off_reg   <= a_off;
                        state_reg <= S_APLAN;
                    end
                end

                S_APLAN:
                begin
                    rest_reg  <= res_reg.len - off_reg;
                    start_reg <= res_reg.base + off_reg;
                    state_reg <= S_ACOMMIT;
                end

                S_ACOMMIT:
                begin
                    if (bfha_pkg::CNT_W'(need) > res_reg.free_cnt)
                    begin
                        res_status_reg <= bfha_pkg::ST_FULL;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        if (off_reg != '0)
                        begin
                            // leading bytes stay a hole in the chosen entry
                            wcmd_reg[0] <= '{1'b1, res_reg.idx, res_reg.base, off_reg,
                                             1'b1, 1'b1};
                            wcmd_reg[1] <= '{1'b1, res_reg.free1, start_reg,
                                             query_reg.size, 1'b0, 1'b1};
                            wcmd_reg[2] <= '{small_req, res_reg.free2, start_plus_n,
                                             rest_minus_n, 1'b1, 1'b1};
                        end
                        else
                        begin
                            wcmd_reg[0] <= '{1'b1, res_reg.idx, start_reg,
                                             query_reg.size, 1'b0, 1'b1};
                            wcmd_reg[1] <= '{small_req, res_reg.free1, start_plus_n,
                                             rest_minus_n, 1'b1, 1'b1};
                            wcmd_reg[2] <= '0;
                        end
                        bytes_used_reg <= used_sat;
                        res_addr_reg   <= start_reg;
                        then_c_reg     <= 1'b0;
                        wptr_reg       <= '0;
                        state_reg      <= S_WRITE;
                    end
                end

                S_FREE_A:
                begin
                    if (!res_reg.found)
                    begin
                        res_status_reg <= bfha_pkg::ST_NOTFOUND;
                        state_reg      <= S_DONE;
                    end
                    else
                    begin
                        i_idx_reg         <= res_reg.idx;
                        i_base_reg        <= res_reg.base;
                        i_len_reg         <= res_reg.len;
                        query_reg.mode    <= bfha_pkg::MODE_END;
                        query_reg.skip_en <= 1'b1;
                        query_reg.skip    <= res_reg.idx;
                        phase_reg         <= PH_B;
                        launch_reg        <= 1'b1;
                        state_reg         <= S_SCAN;
                    end
                end

                S_FREE_B:
                begin
                    if (res_reg.found && res_reg.hole)
                    begin
                        // merge into the hole that ends where this block starts
                        cur_idx_reg  <= res_reg.idx;
                        cur_base_reg <= res_reg.base;
                        cur_len_reg  <= b_sum;
                        wcmd_reg[0]  <= '{1'b1, res_reg.idx, res_reg.base, b_sum,
                                          1'b1, 1'b1};
                        wcmd_reg[1]  <= '{1'b1, i_idx_reg, i_base_reg, i_len_reg,
                                          1'b0, 1'b0};
                    end
                    else
                    begin
                        cur_idx_reg  <= i_idx_reg;
                        cur_base_reg <= i_base_reg;
                        cur_len_reg  <= i_len_reg;
                        wcmd_reg[0]  <= '{1'b1, i_idx_reg, i_base_reg, i_len_reg,
                                          1'b1, 1'b1};
                        wcmd_reg[1]  <= '0;
                    end
                    wcmd_reg[2] <= '0;
                    then_c_reg  <= 1'b1;
                    wptr_reg    <= '0;
                    state_reg   <= S_WRITE;
                end

                S_LAUNCH_C:
                begin
                    query_reg.mode    <= bfha_pkg::MODE_START;
                    query_reg.addr    <= c_addr;
                    query_reg.skip_en <= 1'b1;
                    query_reg.skip    <= cur_idx_reg;
                    phase_reg         <= PH_C;
                    launch_reg        <= 1'b1;
                    state_reg         <= S_SCAN;
                end

                S_FREE_C:
                begin
                    if (res_reg.found && res_reg.hole)
                    begin
                        wcmd_reg[0] <= '{1'b1, cur_idx_reg, cur_base_reg, c_sum,
                                         1'b1, 1'b1};
                        wcmd_reg[1] <= '{1'b1, res_reg.idx, res_reg.base, res_reg.len,
                                         1'b0, 1'b0};
                        wcmd_reg[2] <= '0;
                        then_c_reg  <= 1'b0;
                        wptr_reg    <= '0;
                        state_reg   <= S_WRITE;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end

                S_WRITE:
                begin
                    if (wptr_reg == 2'd2)
                    begin
                        wptr_reg  <= '0;
                        state_reg <= then_c_reg ? S_LAUNCH_C : S_DONE;
                    end
                    else
                    begin
                        wptr_reg <= wptr_reg + 2'd1;
                    end
                end

                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg  <= 1'b1;
                        block_addr_reg <= (res_status_reg == bfha_pkg::ST_OK) ? res_addr_reg
                                                                              : '0;
                        status_reg     <= res_status_reg;
                        used_bytes_reg <= bytes_used_reg;
                        state_reg      <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* rtl/core/best_fit_heap_allocator_top.sv */
// best-fit heap allocator: sequencer plus a chain of table-entry cells
// depends on bfha_pkg, bfha_cell, bfha_ctrl
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_stall     func, req_size, free_addr
//   out      output     out_valid / out_stall   block_addr, status, used_bytes
//   cfg      input      cfg_we                  cfg_index, cfg_data
//
// a scan walks the 64-cell chain at one cell per cycle; the sequencer captures the last cell's packet
// alloc: one scan, then planning, entry writes and output
// free: up to three scans with writes in between; zero size: no scan
// a config write rebuilds the table in the same cycle; reset leaves one empty hole
// a held result does not block input: the next request runs and waits in its last
// state until the output register frees
module best_fit_heap_allocator_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [1:0]                   func,
    input  logic [bfha_pkg::DATA_W-1:0]  req_size,
    input  logic [bfha_pkg::DATA_W-1:0]  free_addr,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [bfha_pkg::DATA_W-1:0]  block_addr,
    output logic [2:0]                   status,
    output logic [bfha_pkg::DATA_W-1:0]  used_bytes,
    input  logic                         cfg_we,
    input  logic                         cfg_index,
    input  logic [bfha_pkg::DATA_W-1:0]  cfg_data
);

    bfha_pkg::query_t   query;
    bfha_pkg::wr_t      wr;
    bfha_pkg::rebuild_t rebuild;
    bfha_pkg::pkt_t     chain [bfha_pkg::TABLE_ENTRIES+1];

    bfha_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .func       (func),
        .req_size   (req_size),
        .free_addr  (free_addr),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .block_addr (block_addr),
        .status     (status),
        .used_bytes (used_bytes),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .query      (query),
        .wr         (wr),
        .rebuild    (rebuild),
        .chain_in   (chain[0]),
        .chain_out  (chain[bfha_pkg::TABLE_ENTRIES])
    );

    for (genvar g = 0; g < bfha_pkg::TABLE_ENTRIES; g++)
    begin : g_cell
        bfha_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (bfha_pkg::IDX_W'(g)),
            .query    (query),
            .wr       (wr),
            .rebuild  (rebuild),
            .pkt_in   (chain[g]),
            .pkt_out  (chain[g+1])
        );
    end

endmodule

/* rtl/core/bfha_checker.sv */
// port-level checks for the best-fit heap allocator, bound to the top level
// depends on bfha_pkg and best_fit_heap_allocator_top_macros.svh
`include "best_fit_heap_allocator_top_macros.svh"

module bfha_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [bfha_pkg::DATA_W-1:0]  block_addr,
    input logic [2:0]                   status
);

    logic failed;

    assign failed = out_valid && (status != bfha_pkg::ST_OK);

    // a held result stays offered
    `BFHA_ASSERT_PLAIN(a_out_hold, clk, rst_n, out_valid && out_stall |=> out_valid)

    // failed requests report no address
    `BFHA_ASSERT(a_err_addr, clk, rst_n, failed |-> block_addr == '0, "address on failure")

    // an accepted transaction keeps the block busy
    `BFHA_ASSERT(a_busy, clk, rst_n, in_valid && !in_stall |=> in_stall, "not busy after accept")

    // the block is free for a new transaction once a result appears
    `BFHA_ASSERT_PLAIN(a_idle_on_result, clk, rst_n, $rose(out_valid) |-> !in_stall)

endmodule

bind best_fit_heap_allocator_top bfha_checker u_bfha_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .block_addr (block_addr),
    .status     (status)
);
